// ===== rtl/core/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types, register indexes and constants of the Braille cell servo unit.
// ----------------------------------------------------------------------------
package brl_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PULSE_MIN    = 2'd0,
      CSR_PULSE_MAX    = 2'd1,
      CSR_FRAME_PERIOD = 2'd2,
      CSR_RAISED_ANGLE = 2'd3
   } csr_index_type;

   // Item kinds
   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_LOAD = 1'b1
   } item_kind_type;

   localparam logic [15:0] PULSE_MIN_RST    = 16'd600;
   localparam logic [15:0] PULSE_MAX_RST    = 16'd2400;
   localparam logic [15:0] FRAME_PERIOD_RST = 16'd20000;
   localparam logic [7:0]  RAISED_ANGLE_RST = 8'd90;

   localparam logic [7:0]  ANGLE_FULL = 8'd180;

   // floor(p / 180) == (p * RECIP_180) >> RECIP_SHIFT for p below 2^24
   localparam logic [24:0] RECIP_180   = 25'd23860930;
   localparam int unsigned RECIP_SHIFT = 32;

   localparam int unsigned DOT_COUNT    = 6;
   localparam int unsigned LETTER_COUNT = 26;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [5:0] LETTER_DOTS [LETTER_COUNT] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
      6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
      6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
   };

   // Pulse widths after angle scaling and saturation at the frame period
   typedef struct packed {
      logic [15:0] lowered;
      logic [15:0] raised;
   } pulse_widths_type;

   // Character to dot pattern; non-letters give all dots down
   function automatic logic [5:0] char_to_dots(input logic [7:0] code);
      logic [7:0] folded;
      logic [7:0] offset;
      logic [5:0] dots;
      folded = code;
      if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
         folded = code + CASE_OFFSET;
      end
      offset = folded - CHAR_LOWER_A;
      dots   = 6'd0;
      if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z) begin
         dots = LETTER_DOTS[offset[4:0]];
      end
      return dots;
   endfunction

endpackage

// ===== rtl/core/brl_pulse_calc.sv =====
// ----------------------------------------------------------------------------
// brl_pulse_calc
// Free-running three-stage computation of the lowered and raised pulse widths.
// ----------------------------------------------------------------------------
module brl_pulse_calc (
   input  logic                      clock,
   input  logic [15:0]               pulse_min,
   input  logic [15:0]               pulse_max,
   input  logic [15:0]               frame_period,
   input  logic [7:0]                raised_angle,
   output brl_pkg::pulse_widths_type widths
);

   logic [15:0] span;
   logic [7:0]  angle;
   logic [23:0] product_ff;
   logic [23:0] product_in;
   logic [48:0] scaled;
   logic [15:0] quot_ff;
   logic [15:0] quot_in;
   logic [15:0] eff_period;
   logic [16:0] raised_sum;
   brl_pkg::pulse_widths_type widths_ff;
   brl_pkg::pulse_widths_type widths_in;

   // stage 1: span times angle
   always_comb begin
      span       = (pulse_max > pulse_min) ? (pulse_max - pulse_min) : 16'd0;
      angle      = (raised_angle > brl_pkg::ANGLE_FULL) ? brl_pkg::ANGLE_FULL : raised_angle;
      product_in = 24'(span) * 24'(angle);
   end

   // stage 2: divide by 180 through the reciprocal
   always_comb begin
      scaled  = 49'(product_ff) * 49'(brl_pkg::RECIP_180);
      quot_in = scaled[brl_pkg::RECIP_SHIFT +: 16];
   end

   // stage 3: add min, saturate at the effective period
   always_comb begin
      eff_period = (frame_period == 16'd0) ? 16'd1 : frame_period;
      raised_sum = 17'(pulse_min) + 17'(quot_ff);
      widths_in.raised  = (raised_sum > 17'(eff_period)) ? eff_period : raised_sum[15:0];
      widths_in.lowered = (pulse_min > eff_period) ? eff_period : pulse_min;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      quot_ff    <= quot_in;
      widths_ff  <= widths_in;
   end

   assign widths = widths_ff;

endmodule

// ===== rtl/core/braille_cell_servo_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// braille_cell_servo_pwm_unit
// Six servo PWM lines for one six-dot Braille cell, one item per microsecond.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  req     | in        | req_valid/req_stall | req_kind, req_char_code
//  rsp     | out       | rsp_valid/rsp_stall | rsp_servo_lines, rsp_frame_start,
//          |           |                    | rsp_shown_pattern
//  csr     | in        | csr_write          | csr_index, csr_wdata
//
//  One item per cycle sustained while no result is held; every item's result
//  passes through the item stages into the result register.
//  The item stages match the pulse width unit (multiply, reciprocal multiply,
//  saturate), which settles once a register write reaches its width register.
//  Frame state is updated at the edge an item is accepted; the result
//  pipeline carries a snapshot of it.
//  A stalled result holds the whole pipeline and raises req_stall.
//  Synchronous reset restores register defaults and clears frame state and valid bits.
//
module braille_cell_servo_pwm_unit (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_char_code,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_servo_lines,
   output logic        rsp_frame_start,
   output logic [5:0]  rsp_shown_pattern,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // item stages ahead of the result register; matches pulse calc latency
   localparam int unsigned STAGES = 3;

   // ---------------------------------------------------------------- config
   logic [15:0] pulse_min_ff;
   logic [15:0] pulse_max_ff;
   logic [15:0] frame_period_ff;
   logic [7:0]  raised_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff    <= brl_pkg::PULSE_MIN_RST;
         pulse_max_ff    <= brl_pkg::PULSE_MAX_RST;
         frame_period_ff <= brl_pkg::FRAME_PERIOD_RST;
         raised_angle_ff <= brl_pkg::RAISED_ANGLE_RST;
      end else if (csr_write) begin
         case (brl_pkg::csr_index_type'(csr_index))
            brl_pkg::CSR_PULSE_MIN:    pulse_min_ff    <= csr_wdata;
            brl_pkg::CSR_PULSE_MAX:    pulse_max_ff    <= csr_wdata;
            brl_pkg::CSR_FRAME_PERIOD: frame_period_ff <= csr_wdata;
            brl_pkg::CSR_RAISED_ANGLE: raised_angle_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   brl_pkg::pulse_widths_type widths;

   brl_pulse_calc u_pulse_calc (
      .clock        (clock),
      .pulse_min    (pulse_min_ff),
      .pulse_max    (pulse_max_ff),
      .frame_period (frame_period_ff),
      .raised_angle (raised_angle_ff),
      .widths       (widths)
   );

   // ---------------------------------------------------------------- frame state
   logic        advance;
   logic        accept;
   logic        is_tick;
   logic [15:0] frame_count_ff, frame_count_in;
   logic [5:0]  active_ff, active_in;
   logic [5:0]  pending_ff, pending_in;
   logic        start_now;
   logic [16:0] count_plus;
   logic [16:0] eff_period;

   // whole pipeline moves unless a finished result is held
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign is_tick   = (brl_pkg::item_kind_type'(req_kind) == brl_pkg::KIND_TICK);

   always_comb begin
      frame_count_in = frame_count_ff;
      active_in      = active_ff;
      pending_in     = pending_ff;
      start_now      = 1'b0;
      count_plus     = 17'(frame_count_ff) + 17'd1;
      eff_period     = (frame_period_ff == 16'd0) ? 17'd1 : 17'(frame_period_ff);
      if (is_tick) begin
         if (frame_count_ff == 16'd0) begin
            start_now = 1'b1;
            active_in = pending_ff;
         end
         // a shrunken period returns the counter to zero here
         frame_count_in = (count_plus >= eff_period) ? 16'd0 : count_plus[15:0];
      end else begin
         pending_in = brl_pkg::char_to_dots(req_char_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= 16'd0;
         active_ff      <= 6'd0;
         pending_ff     <= 6'd0;
      end else if (accept) begin
         frame_count_ff <= frame_count_in;
         active_ff      <= active_in;
         pending_ff     <= pending_in;
      end
   end

   // ---------------------------------------------------------------- item pipeline
   // snapshot: counter before the update, pattern after it
   logic        stage_valid_ff [STAGES];
   logic [15:0] stage_count_ff [STAGES];
   logic [5:0]  stage_pattern_ff [STAGES];
   logic        stage_start_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            stage_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         stage_valid_ff[0] <= req_valid;
         for (int k = 1; k < STAGES; k++) begin
            stage_valid_ff[k] <= stage_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_count_ff[0]   <= frame_count_ff;
         stage_pattern_ff[0] <= active_in;
         stage_start_ff[0]   <= start_now;
         for (int k = 1; k < STAGES; k++) begin
            stage_count_ff[k]   <= stage_count_ff[k-1];
            stage_pattern_ff[k] <= stage_pattern_ff[k-1];
            stage_start_ff[k]   <= stage_start_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- result
   logic       rsp_valid_ff;
   logic [5:0] lines_ff, lines_in;
   logic [5:0] shown_ff;
   logic       start_ff;

   // each line is high while the counter is below its dot's width
   always_comb begin
      for (int i = 0; i < brl_pkg::DOT_COUNT; i++) begin
         lines_in[i] = stage_pattern_ff[STAGES-1][i] ?
                       (stage_count_ff[STAGES-1] < widths.raised) :
                       (stage_count_ff[STAGES-1] < widths.lowered);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lines_ff <= lines_in;
         shown_ff <= stage_pattern_ff[STAGES-1];
         start_ff <= stage_start_ff[STAGES-1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_servo_lines   = lines_ff;
   assign rsp_frame_start   = start_ff;
   assign rsp_shown_pattern = shown_ff;

   // ---------------------------------------------------------------- checks
   // a tick either steps the counter by one or wraps it to zero
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      accept && is_tick |=>
         (frame_count_ff == 16'd0) || (frame_count_ff == $past(frame_count_ff) + 16'd1))
      else $error("frame counter took an illegal step");

   // a load never moves time or the driven pattern
   a_load_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !is_tick |=> $stable(frame_count_ff) && $stable(active_ff))
      else $error("load item disturbed frame state");

   // a held result freezes the item pipeline
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(stage_valid_ff[STAGES-1]) && $stable(stage_count_ff[STAGES-1]))
      else $error("pipeline moved under a held result");

   // a frame start in a result always shows a counter of zero
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[STAGES-1] && stage_start_ff[STAGES-1] |->
         stage_count_ff[STAGES-1] == 16'd0)
      else $error("frame start with nonzero count");

endmodule

// ===== tb/braille_cell_servo_pwm_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// braille_cell_servo_pwm_unit_test
// Self-checking bench for the Braille cell servo PWM unit. A directed table
// covers reset values, character mapping edges and register extremes. Random
// phases follow, each with new register values and its own mix of sender
// gaps and result stalls. Typed rows are checked against their table values,
// others against a cycle-free model of frame counter, dots and pulse widths.
// ----------------------------------------------------------------------------
module braille_cell_servo_pwm_unit_test;
   import brl_pkg::*;

   // One result item as the block presents it
   typedef struct packed {
      logic [5:0] lines;
      logic       frame_start;
      logic [5:0] shown;
   } cell_result_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_REG  = 1'b1
   } row_op_type;

   // One row of the directed table: an item or a register write.
   // typed rows carry a result read straight off the spec.
   typedef struct packed {
      row_op_type      op;
      item_kind_type   kind;
      logic [7:0]      code;
      csr_index_type   reg_idx;
      logic [15:0]     wdata;
      logic            typed;
      cell_result_type want;
   } plan_row_type;

   localparam int CLOCK_HALF   = 6;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_ITEMS  = 100;
   localparam int REPORT_LINES = 20;

   // Standard six-dot patterns for a..z, bit i is dot i+1
   localparam logic [5:0] DOTS_OF_LETTER [26] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
      6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
      6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
   };

   localparam int PLAN_ROWS = 38;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // fresh from reset: first tick starts a frame with all dots down
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b1, 6'h00}},
      '{ROW_ITEM, KIND_LOAD, 8'h41, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b0, 6'h00}},
      // letter range edges and non-letters
      '{ROW_ITEM, KIND_LOAD, 8'h7A, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h5A, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h40, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h5B, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h60, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h7B, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'hFF, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h6D, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      // period shrinks to one, no longer above the running counter
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_FRAME_PERIOD, 16'd1, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h00, 1'b0, 6'h00}},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b1, 6'h0D}},
      // period zero acts as one
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_FRAME_PERIOD, 16'd0, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b1, 6'h0D}},
      // angle over 180, full span, widest period
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_RAISED_ANGLE, 16'h00FF, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MAX, 16'hFFFF, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_FRAME_PERIOD, 16'hFFFF, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h5A, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h0D, 1'b0, 6'h0D}},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h35, 1'b1, 6'h35}},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h35, 1'b0, 6'h35}},
      // max below min, zero angle, widths saturate at a tiny period
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'hFFFF, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MAX, 16'h0000, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_RAISED_ANGLE, 16'h0000, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_FRAME_PERIOD, 16'd3, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b0, 6'h35}},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b1, '{6'h3F, 1'b1, 6'h35}},
      // exact 180 degrees, short frame
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'd10, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_PULSE_MAX, 16'd20, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_RAISED_ANGLE, 16'd180, 1'b0, '0},
      '{ROW_REG,  KIND_TICK, 8'h00, CSR_FRAME_PERIOD, 16'd16, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h62, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_LOAD, 8'h77, CSR_PULSE_MIN, 16'h0000, 1'b0, '0},
      '{ROW_ITEM, KIND_TICK, 8'h00, CSR_PULSE_MIN, 16'h0000, 1'b0, '0}
   };

   // DUT connections; the inputs are driven to known values from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_servo_lines;
   logic        rsp_frame_start;
   logic [5:0]  rsp_shown_pattern;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'h0000;

   // Local copy of the registers and frame state
   logic [15:0] min_us    = PULSE_MIN_RST;
   logic [15:0] max_us    = PULSE_MAX_RST;
   logic [15:0] period_us = FRAME_PERIOD_RST;
   logic [7:0]  lift_angle = RAISED_ANGLE_RST;
   logic [15:0] frame_count = '0;
   logic [5:0]  active_dots = '0;
   logic [5:0]  pending_dots = '0;

   cell_result_type cell_results_due [$];
   cell_result_type oldest_due;

   // idle and stall odds in percent, set per phase
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   int mismatches = 0;
   int cycles = 0;
   int items_sent = 0;
   int loads_sent = 0;
   int reg_writes = 0;
   int starts_seen = 0;

   braille_cell_servo_pwm_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_servo_lines   (rsp_servo_lines),
      .rsp_frame_start   (rsp_frame_start),
      .rsp_shown_pattern (rsp_shown_pattern),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Cell model
   // ---------------------------------------------------------------------

   // Folds upper case, anything outside a..z shows no dots
   function automatic logic [5:0] dots_of_char(input logic [7:0] code);
      logic [7:0] folded;
      folded = code;
      if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
         folded = code + CASE_OFFSET;
      end
      if (folded < CHAR_LOWER_A || folded > CHAR_LOWER_Z) begin
         return 6'h00;
      end
      return DOTS_OF_LETTER[folded - CHAR_LOWER_A];
   endfunction

   function automatic int unsigned frame_len();
      return (period_us == 16'd0) ? 1 : int'(period_us);
   endfunction

   // Pulse width of one dot, clipped to the frame
   function automatic int unsigned dot_width(input bit raised);
      int unsigned w;
      int unsigned span;
      int unsigned ang;
      w = min_us;
      if (raised) begin
         ang  = (lift_angle > ANGLE_FULL) ? ANGLE_FULL : lift_angle;
         span = (max_us > min_us) ? int'(max_us) - int'(min_us) : 0;
         w    = int'(min_us) + (span * ang) / ANGLE_FULL;
      end
      if (w > frame_len()) begin
         w = frame_len();
      end
      return w;
   endfunction

   function automatic logic [5:0] line_levels();
      logic [5:0] lines;
      lines = '0;
      for (int i = 0; i < DOT_COUNT; i++) begin
         if (frame_count < dot_width(active_dots[i])) begin
            lines[i] = 1'b1;
         end
      end
      return lines;
   endfunction

   // Advances the cell by one item and returns what it should show
   function automatic cell_result_type step_cell(input item_kind_type kind,
                                                 input logic [7:0] code);
      cell_result_type r;
      r.frame_start = 1'b0;
      if (kind == KIND_LOAD) begin
         pending_dots = dots_of_char(code);
      end else if (frame_count == 16'd0) begin
         r.frame_start = 1'b1;
         active_dots   = pending_dots;
      end
      r.lines = line_levels();
      r.shown = active_dots;
      if (kind == KIND_TICK) begin
         frame_count = (32'(frame_count) + 1 >= frame_len()) ? 16'd0 : frame_count + 16'd1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers (called at the falling edge, return at a falling edge)
   // ---------------------------------------------------------------------

   task automatic drive_item(input item_kind_type kind, input logic [7:0] code,
                             input logic typed, input cell_result_type want);
      cell_result_type predicted;
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_char_code <= code;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // accepted at this edge: move the model along in step
      predicted = step_cell(kind, code);
      cell_results_due.push_back(typed ? want : predicted);
      items_sent++;
      if (kind == KIND_LOAD) begin
         loads_sent++;
      end
      @(negedge clock);
   endtask

   // Register writes only with the block drained and the input idle
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      req_valid <= 1'b0;
      while (cell_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PULSE_MIN:    min_us     = value;
         CSR_PULSE_MAX:    max_us     = value;
         CSR_FRAME_PERIOD: period_us  = value;
         CSR_RAISED_ANGLE: lift_angle = value[7:0];
         default: ;
      endcase
      reg_writes++;
      // let the width unit settle after a write
      repeat (4) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= REPORT_LINES) begin
         $display("ERROR cycle %0d: %s got %0h want %0h", cycles, what, got, want);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, compare in order, watchdog
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", cell_results_due.size());
         $display("simulation failed");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_results_due.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_servo_lines, 0);
         end else begin
            oldest_due = cell_results_due.pop_front();
            if (rsp_servo_lines !== oldest_due.lines) begin
               report_mismatch("servo_lines", rsp_servo_lines, oldest_due.lines);
            end
            if (rsp_frame_start !== oldest_due.frame_start) begin
               report_mismatch("frame_start", rsp_frame_start, oldest_due.frame_start);
            end
            if (rsp_shown_pattern !== oldest_due.shown) begin
               report_mismatch("shown_pattern", rsp_shown_pattern, oldest_due.shown);
            end
         end
         if (rsp_frame_start === 1'b1) begin
            starts_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      item_kind_type kind;
      logic [7:0]    code;
      logic [15:0]   new_period;
      logic [15:0]   new_min;
      logic [15:0]   new_max;
      logic [15:0]   new_angle;
      int            span_top;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no gaps or stalls
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].op == ROW_REG) begin
            write_reg(PLAN[r].reg_idx, PLAN[r].wdata);
         end else begin
            drive_item(PLAN[r].kind, PLAN[r].code, PLAN[r].typed, PLAN[r].want);
         end
      end

      // random phases: fresh registers, then a burst of items
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 7))
            0:       new_period = 16'd0;
            1:       new_period = 16'hFFFF;
            2:       new_period = 16'd1;
            default: new_period = 16'($urandom_range(2, 40));
         endcase
         // keep widths near the frame so lines actually toggle
         span_top = (new_period == 16'd0 || new_period == 16'hFFFF) ? 60 : new_period + 4;
         case ($urandom_range(0, 7))
            0:       new_min = 16'h0000;
            1:       new_min = 16'hFFFF;
            2:       new_min = 16'($urandom_range(0, 65535));
            default: new_min = 16'($urandom_range(0, span_top));
         endcase
         case ($urandom_range(0, 7))
            0:       new_max = 16'h0000;
            1:       new_max = 16'hFFFF;
            default: new_max = 16'($urandom_range(0, 2 * span_top));
         endcase
         case ($urandom_range(0, 5))
            0:       new_angle = 16'd0;
            1:       new_angle = 16'd180;
            2:       new_angle = 16'($urandom_range(181, 255));
            default: new_angle = 16'($urandom_range(0, 180));
         endcase
         write_reg(CSR_PULSE_MIN, new_min);
         write_reg(CSR_PULSE_MAX, new_max);
         write_reg(CSR_RAISED_ANGLE, new_angle);
         write_reg(CSR_FRAME_PERIOD, new_period);

         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 47;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 47;
            end
            default: begin
               sender_idle_pct    = 33;
               receiver_stall_pct = 33;
            end
         endcase

         repeat (PHASE_ITEMS) begin
            // mostly ticks; loads land anywhere in the frame
            kind = ($urandom_range(0, 99) < 20) ? KIND_LOAD : KIND_TICK;
            case ($urandom_range(0, 3))
               0:       code = CHAR_UPPER_A + 8'($urandom_range(0, 25));
               1:       code = CHAR_LOWER_A + 8'($urandom_range(0, 25));
               default: code = 8'($urandom_range(0, 255));
            endcase
            drive_item(kind, code, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      sender_idle_pct = 0;
      while (cell_results_due.size() != 0) begin
         @(posedge clock);
      end
      receiver_stall_pct = 0;
      repeat (10) @(posedge clock);

      $display("%0d items checked (%0d character loads), %0d frame starts",
               items_sent, loads_sent, starts_seen);
      $display("%0d register writes over %0d random phases, %0d mismatches",
               reg_writes, PHASE_COUNT, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== braille_cell_servo_pwm_unit.f =====
rtl/core/brl_pkg.sv
rtl/core/brl_pulse_calc.sv
rtl/core/braille_cell_servo_pwm_unit.sv
tb/braille_cell_servo_pwm_unit_test.sv
